[rtl/dpc_pkg.sv]
`timescale 1ns / 1ps
// dpc_pkg: widths, constants, types and the log table builder for the dew point core
// used by every module of the core except dpc_div; depends on nothing
package dpc_pkg;

	localparam int FRACTION_BITS_DEF   = 16;
	localparam int LOG_TABLE_DEPTH_DEF = 256;
	localparam int QUEUE_DEPTH         = 2;

	localparam int RAW_T_W = 14;
	localparam int RAW_H_W = 14;
	localparam int TOFF_W  = 11;
	localparam int HOFF_W  = 12;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 1;
	localparam int TEMP_W  = 15;
	localparam int HUM_W   = 14;
	localparam int DEWC_W  = 15;
	localparam int DEWF_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_OFFSET = 1'b0,
		REG_HUM_OFFSET  = 1'b1
	} cfg_reg_t;

	localparam int HUM_MAX     = 10000;
	localparam int HUM_MAX_MSB = 13;
	localparam int DEW_LIMIT   = 9000;
	localparam int F_OFFSET    = 3200;

	// magnus coefficients: a in tenths, b in hundredths like the temperature (used as b*10)
	localparam int A_WARM   = 75;
	localparam int A_COLD   = 76;
	localparam int B_WARM   = 23730;
	localparam int B_COLD   = 24070;

	localparam longint unsigned Q30         = 64'd1 << 30;
	localparam longint unsigned LOG10_2_Q32 = 64'd1292913987;

	// m/5 as (m * DIV5_RECIP) >> DIV5_SHIFT, exact for m below 2^20
	localparam int DIV5_RECIP = 838861;
	localparam int DIV5_SHIFT = 22;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
		logic                     ok;
	} job_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_G_SET,
		BK_G_DIV,
		BK_LOG_IDX,
		BK_LOG_ROM,
		BK_LOG_MUL,
		BK_LOG_SUM,
		BK_LOG_SCALE,
		BK_DEW_SET,
		BK_DEW_DIV,
		BK_FAHR,
		BK_DONE
	} back_state_t;

	// log2(x / 2^30) as a fraction with fb bits, x in [2^30, 2^31]
	function automatic longint unsigned log_entry(longint unsigned x0, int fb);
		longint unsigned x;
		longint unsigned acc;
		x = x0;
		acc = 0;
		if (x >= 2 * Q30) begin
			acc = 64'd1 << fb;
		end else begin
			for (int bit_i = fb - 1; bit_i >= 0; bit_i--) begin
				x = (x * x) >> 30;
				if (x >= 2 * Q30) begin
					acc = acc | (64'd1 << bit_i);
					x = x >> 1;
				end
			end
		end
		return acc;
	endfunction

endpackage

[rtl/dpc_front.sv]
`timescale 1ns / 1ps
// dpc_front: offset registers, held readings and job issue into the queue
// depends on dpc_pkg
module dpc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [dpc_pkg::RAW_T_W-1:0]   raw_temperature,
	input  logic                                 temperature_valid,
	input  logic [dpc_pkg::RAW_H_W-1:0]          raw_humidity,
	input  logic                                 humidity_valid,
	input  logic                                 cfg_write_en,
	input  logic [dpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dpc_pkg::CFG_W-1:0]            cfg_data,
	output logic                                 push,
	output dpc_pkg::job_t                        push_data,
	input  logic                                 full
);
	import dpc_pkg::*;

	logic signed [TOFF_W-1:0] temp_offset_q;
	logic signed [HOFF_W-1:0] hum_offset_q;
	logic signed [TEMP_W-1:0] held_temp_q;
	logic [HUM_W-1:0]         held_hum_q;
	logic                     have_temp_q;
	logic                     have_hum_q;

	logic signed [TEMP_W-1:0] temp_next;
	logic signed [15:0]       hum_sum;
	logic [HUM_W-1:0]         hum_next;
	logic                     have_temp_next;
	logic                     have_hum_next;

	assign in_stall = full;
	assign push     = in_valid && !full;

	always_comb begin
		hum_sum = $signed({2'b00, raw_humidity}) + 16'(hum_offset_q);
		temp_next = held_temp_q;
		hum_next = held_hum_q;
		if (temperature_valid) begin
			temp_next = TEMP_W'(raw_temperature) + TEMP_W'(temp_offset_q);
		end
		if (humidity_valid) begin
			if (hum_sum < 0) begin
				hum_next = '0;
			end else if (hum_sum > 16'(HUM_MAX)) begin
				hum_next = HUM_W'(HUM_MAX);
			end else begin
				hum_next = hum_sum[HUM_W-1:0];
			end
		end
		have_temp_next = have_temp_q || temperature_valid;
		have_hum_next  = have_hum_q || humidity_valid;
	end

	always_comb begin
		push_data.temp = temp_next;
		push_data.hum  = hum_next;
		push_data.ok   = have_temp_next && have_hum_next && (hum_next != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_offset_q <= '0;
			hum_offset_q  <= '0;
			held_temp_q   <= '0;
			held_hum_q    <= '0;
			have_temp_q   <= 1'b0;
			have_hum_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_TEMP_OFFSET: temp_offset_q <= cfg_data[TOFF_W-1:0];
					REG_HUM_OFFSET:  hum_offset_q  <= cfg_data[HOFF_W-1:0];
					default: ;
				endcase
			end
			if (push) begin
				held_temp_q <= temp_next;
				held_hum_q  <= hum_next;
				have_temp_q <= have_temp_next;
				have_hum_q  <= have_hum_next;
			end
		end
	end

endmodule

[rtl/dpc_fifo.sv]
`timescale 1ns / 1ps
// dpc_fifo: short job queue between front and back
// depends on dpc_pkg
module dpc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dpc_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output dpc_pkg::job_t pop_data,
	output logic          empty
);
	import dpc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t           mem [0:QUEUE_DEPTH-1];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [PW:0]    cnt_q;

	assign full     = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/dpc_div.sv]
`timescale 1ns / 1ps
// dpc_div: unsigned restoring divider, one quotient bit per cycle
// depends on nothing outside this file
module dpc_div #(
	parameter int W = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    shifted;
	logic          fits;

	assign shifted  = {rem_q, quo_q[W-1]};
	assign fits     = (shifted >= {1'b0, den_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? W'(shifted - {1'b0, den_q}) : W'(shifted);
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/dpc_back.sv]
`timescale 1ns / 1ps
// dpc_back: magnus sequencer with log table, shared divider and result register
// depends on dpc_pkg and dpc_div
module dpc_back #(
	parameter int FRACTION_BITS   = dpc_pkg::FRACTION_BITS_DEF,
	parameter int LOG_TABLE_DEPTH = dpc_pkg::LOG_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	input  dpc_pkg::job_t                       pop_data,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dpc_pkg::TEMP_W-1:0]   adjusted_temperature,
	output logic [dpc_pkg::HUM_W-1:0]           adjusted_humidity,
	output logic signed [dpc_pkg::DEWC_W-1:0]   dew_point_c,
	output logic signed [dpc_pkg::DEWF_W-1:0]   dew_point_f,
	output logic                                dew_valid
);
	import dpc_pkg::*;

	localparam int FB    = FRACTION_BITS;
	localparam int DEPTH = LOG_TABLE_DEPTH;
	localparam int LW    = FB + 4;
	localparam int VW    = FB + 5;
	localparam int DW    = FB + 24;
	localparam int IW    = $clog2(DEPTH + 1);
	localparam int DEN_W = FB + 9;
	localparam int PW    = 30 + IW;

	// log2 of full scale humidity, worked out at elaboration
	localparam longint unsigned LF_F = (64'(HUM_MAX) << (30 - HUM_MAX_MSB)) - Q30;
	localparam longint unsigned LF_P = LF_F * DEPTH;
	localparam longint unsigned LF_I = LF_P >> 30;
	localparam longint unsigned LF_R = LF_P & (Q30 - 1);
	localparam longint unsigned LF_XLO = ((DEPTH + LF_I) * Q30) / DEPTH;
	localparam longint unsigned LF_XHI = ((DEPTH + LF_I + 1) * Q30) / DEPTH;
	localparam longint unsigned LF_LO = log_entry(LF_XLO, FB);
	localparam longint unsigned LF_HI = log_entry(LF_XHI, FB);
	localparam longint unsigned LG_FULL =
		(64'(HUM_MAX_MSB) << FB) + LF_LO + (((LF_HI - LF_LO) * LF_R) >> 30);
	localparam logic [LW-1:0] LG_FULL_W = LW'(LG_FULL);

	logic [FB:0] rom_w [0:DEPTH];

	for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
		localparam longint unsigned RX = ((64'(DEPTH) + k) * Q30) / DEPTH;
		assign rom_w[k] = (FB+1)'(log_entry(RX, FB));
	end

	back_state_t st_q, st_next;

	job_t                     job_q;
	logic                     sign_q;
	logic signed [VW-1:0]     g_q;
	logic [3:0]               e_q;
	logic [IW-1:0]            idx_q;
	logic [29:0]              r_q;
	logic [FB:0]              lo_q;
	logic [FB:0]              hi_q;
	logic [FB:0]              frac_q;
	logic [LW-1:0]            d_q;
	logic [LW-1:0]            lmag_q;
	logic signed [DEWC_W-1:0] c_q;
	logic [14:0]              q5_q;
	logic                     out_valid_q;

	logic          div_start;
	logic          div_done;
	logic [DW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic [DW-1:0] div_quo;
	logic          out_load;

	logic signed [7:0]        a_val;
	logic [17:0]              b10_val;
	logic signed [23:0]       at;
	logic [22:0]              at_mag;
	logic [23:0]              g_den;
	logic [3:0]               e_c;
	logic [30:0]              sh;
	logic [PW-1:0]            p;
	logic [IW-1:0]            idx_c;
	logic [FB:0]              diff;
	logic [FB+30:0]           frac_prod;
	logic [LW-1:0]            lgh;
	logic [LW+30:0]           scale_prod;
	logic signed [VW-1:0]     v;
	logic [VW-1:0]            v_mag;
	logic [VW+17:0]           dew_num;
	logic signed [DEN_W-1:0]  den_s;
	logic [DEN_W-1:0]         den_c;
	logic [16:0]              fm;
	logic [36:0]              f_prod;
	logic [DEWC_W-1:0]        c_mag;
	logic signed [DEWC_W-1:0] c_sat;
	logic signed [DEWF_W-1:0] f_val;

	dpc_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// coefficient choice and the datapath of every step
	always_comb begin
		a_val   = job_q.temp[TEMP_W-1] ? 8'(A_COLD) : 8'(A_WARM);
		b10_val = job_q.temp[TEMP_W-1] ? 18'(B_COLD * 10) : 18'(B_WARM * 10);
		at      = 24'(a_val) * 24'(job_q.temp);
		at_mag  = at[23] ? 23'(-at) : 23'(at);
		g_den   = (24'(job_q.temp) + (job_q.temp[TEMP_W-1] ? 24'(B_COLD) : 24'(B_WARM)))
			* 24'(10);

		e_c = '0;
		for (int b = 0; b < HUM_W; b++) begin
			if (job_q.hum[b]) begin
				e_c = 4'(b);
			end
		end
		sh    = 31'(job_q.hum) << (5'd30 - {1'b0, e_c});
		p     = PW'(sh[29:0]) * PW'(DEPTH);
		idx_c = (p[PW-1:30] >= IW'(DEPTH)) ? IW'(DEPTH - 1) : p[PW-1:30];

		diff      = (hi_q > lo_q) ? hi_q - lo_q : '0;
		frac_prod = (FB+31)'(diff) * (FB+31)'(r_q);
		lgh       = (LW'(e_q) << FB) + LW'(lo_q) + LW'(frac_q);
		scale_prod = (LW+31)'(d_q) * (LW+31)'(LOG10_2_Q32);

		v       = g_q - VW'(lmag_q);
		v_mag   = v[VW-1] ? VW'(-v) : VW'(v);
		dew_num = (VW+18)'(v_mag) * (VW+18)'(b10_val);
		den_s   = (DEN_W'(a_val) <<< FB) - DEN_W'(v) * DEN_W'(10);
		den_c   = (den_s[DEN_W-1] || den_s == '0) ? DEN_W'(1) : DEN_W'(den_s);

		c_mag = (div_quo > DW'(DEW_LIMIT)) ? DEWC_W'(DEW_LIMIT) : div_quo[DEWC_W-1:0];
		c_sat = sign_q ? -$signed(c_mag) : $signed(c_mag);

		fm     = c_q[DEWC_W-1] ? 17'(-c_q) * 17'(9) + 17'(2) : 17'(c_q) * 17'(9) + 17'(2);
		f_prod = 37'(fm) * 37'(DIV5_RECIP);
		f_val  = c_q[DEWC_W-1] ? DEWF_W'(F_OFFSET) - DEWF_W'(q5_q)
			: DEWF_W'(F_OFFSET) + DEWF_W'(q5_q);

		if (st_q == BK_G_SET) begin
			div_num = DW'(at_mag) << FB;
			div_den = DW'(g_den);
		end else begin
			div_num = DW'(dew_num);
			div_den = DW'(den_c);
		end
	end

	// next state
	always_comb begin
		st_next = st_q;
		case (st_q)
			BK_IDLE:      if (!empty) st_next = pop_data.ok ? BK_G_SET : BK_DONE;
			BK_G_SET:     st_next = BK_G_DIV;
			BK_G_DIV:     if (div_done) st_next = BK_LOG_IDX;
			BK_LOG_IDX:   st_next = BK_LOG_ROM;
			BK_LOG_ROM:   st_next = BK_LOG_MUL;
			BK_LOG_MUL:   st_next = BK_LOG_SUM;
			BK_LOG_SUM:   st_next = BK_LOG_SCALE;
			BK_LOG_SCALE: st_next = BK_DEW_SET;
			BK_DEW_SET:   st_next = BK_DEW_DIV;
			BK_DEW_DIV:   if (div_done) st_next = BK_FAHR;
			BK_FAHR:      st_next = BK_DONE;
			BK_DONE:      if (!out_valid_q || !out_stall) st_next = BK_IDLE;
			default:      st_next = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (st_q)
			BK_IDLE:    pop = !empty;
			BK_G_SET:   div_start = 1'b1;
			BK_DEW_SET: div_start = 1'b1;
			BK_DONE:    out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				job_q <= pop_data;
				c_q   <= '0;
				q5_q  <= '0;
			end
			BK_G_SET: sign_q <= job_q.temp[TEMP_W-1];
			BK_G_DIV: g_q <= sign_q ? -$signed(VW'(div_quo)) : $signed(VW'(div_quo));
			BK_LOG_IDX: begin
				e_q   <= e_c;
				idx_q <= idx_c;
				r_q   <= p[29:0];
			end
			BK_LOG_ROM: begin
				lo_q <= rom_w[idx_q];
				hi_q <= rom_w[IW'(idx_q + 1'b1)];
			end
			BK_LOG_MUL:   frac_q <= frac_prod[FB+30:30];
			BK_LOG_SUM:   d_q <= (LG_FULL_W > lgh) ? LG_FULL_W - lgh : '0;
			BK_LOG_SCALE: lmag_q <= LW'(scale_prod[LW+30:32]);
			BK_DEW_SET:   sign_q <= v[VW-1];
			BK_DEW_DIV:   c_q <= c_sat;
			BK_FAHR:      q5_q <= f_prod[36:DIV5_SHIFT];
			default: ;
		endcase
		if (out_load) begin
			adjusted_temperature <= job_q.temp;
			adjusted_humidity    <= job_q.hum;
			dew_point_c          <= job_q.ok ? c_q : '0;
			dew_point_f          <= job_q.ok ? f_val : '0;
			dew_valid            <= job_q.ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/dew_point_calculator_core.sv]
// dew point core: one result word per input word, in order
// the back finishes one word before it takes the next, using the bit-serial divider twice per word
// asynchronous active-low reset clears the offsets, held readings, queue and sequencer
`timescale 1ns / 1ps
module dew_point_calculator_core #(
	parameter int FRACTION_BITS   = dpc_pkg::FRACTION_BITS_DEF,
	parameter int LOG_TABLE_DEPTH = dpc_pkg::LOG_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [dpc_pkg::RAW_T_W-1:0]  raw_temperature,
	input  logic                                temperature_valid,
	input  logic [dpc_pkg::RAW_H_W-1:0]         raw_humidity,
	input  logic                                humidity_valid,
	input  logic                                cfg_write_en,
	input  logic [dpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpc_pkg::CFG_W-1:0]           cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dpc_pkg::TEMP_W-1:0]   adjusted_temperature,
	output logic [dpc_pkg::HUM_W-1:0]           adjusted_humidity,
	output logic signed [dpc_pkg::DEWC_W-1:0]   dew_point_c,
	output logic signed [dpc_pkg::DEWF_W-1:0]   dew_point_f,
	output logic                                dew_valid
);
	import dpc_pkg::*;

	// front: offsets and held readings; every accepted word becomes one job
	// queue: a couple of jobs so the front keeps taking words while the back works
	// back: g = a*t/(b+t), log10 of humidity via table, then b*v/(a-v) and fahrenheit

	logic push;
	logic full;
	logic pop;
	logic empty;
	job_t push_data;
	job_t pop_data;

	dpc_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.raw_temperature   (raw_temperature),
		.temperature_valid (temperature_valid),
		.raw_humidity      (raw_humidity),
		.humidity_valid    (humidity_valid),
		.cfg_write_en      (cfg_write_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.push              (push),
		.push_data         (push_data),
		.full              (full)
	);

	dpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// sequencer and output register; the result word waits there under stall
	dpc_back #(
		.FRACTION_BITS   (FRACTION_BITS),
		.LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
	) u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.empty                (empty),
		.pop_data             (pop_data),
		.pop                  (pop),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.adjusted_temperature (adjusted_temperature),
		.adjusted_humidity    (adjusted_humidity),
		.dew_point_c          (dew_point_c),
		.dew_point_f          (dew_point_f),
		.dew_valid            (dew_valid)
	);

	// queue never overflows or underflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("job popped from empty queue");

	// a word without a dew point carries zeros
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dew_valid) |-> (dew_point_c == '0 && dew_point_f == '0))
		else $error("dew fields not cleared");

	// dew point stays inside the saturation band
	a_dew_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dew_valid) |->
		(dew_point_c <= DEWC_W'(DEW_LIMIT) && dew_point_c >= -DEWC_W'(DEW_LIMIT)))
		else $error("dew point out of range");

endmodule
